[src/modbus_rtu_master_transaction_assert.svh]
// ----------------------------------------------------------------------------
// modbus_rtu_master_transaction_assert.svh
// Assertion macros used by the checker file of the Modbus RTU master.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_MASTER_TRANSACTION_ASSERT_SVH
`define MODBUS_RTU_MASTER_TRANSACTION_ASSERT_SVH

// Clocked check, masked while reset is asserted.
`define MRTU_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs through reset.
`define MRTU_CHECK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/mrtu_pkg.sv]
// ----------------------------------------------------------------------------
// mrtu_pkg
// Types, codes and the CRC-16/MODBUS byte update for the RTU master.
// ----------------------------------------------------------------------------
package mrtu_pkg;

  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_RXBYTE = 2'd2,
    KIND_TICK   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_OK      = 2'd0,
    ERR_CRC     = 2'd1,
    ERR_TIMEOUT = 2'd2,
    ERR_BUSY    = 2'd3
  } err_t;

  typedef enum logic {
    OUT_TX   = 1'b0,
    OUT_DONE = 1'b1
  } okind_t;

  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [7:0]  FC_READ         = 8'h03;
  localparam logic [7:0]  FC_WRITE        = 8'h06;
  localparam logic [15:0] READ_QTY        = 16'h0001;
  localparam logic [15:0] TIMEOUT_RESET   = 16'd1000;
  localparam logic [15:0] ELAPSED_MAX     = 16'hFFFF;
  // body length (response length minus the two CRC bytes)
  localparam logic [3:0]  BODY_LEN_READ   = 4'd5;
  localparam logic [3:0]  BODY_LEN_WRITE  = 4'd6;
  localparam logic [3:0]  RX_IDX_DATA_HI  = 4'd3;
  localparam logic [3:0]  RX_IDX_DATA_LO  = 4'd4;
  localparam int          REQ_BODY_BYTES  = 6;
  localparam logic [2:0]  BEAT_CRC_LO     = 3'd6;
  localparam logic [2:0]  BEAT_LAST       = 3'd7;
  localparam logic        REG_TIMEOUT     = 1'b0;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  slave_id;
    logic [15:0] reg_address;
    logic [15:0] write_value;
    logic [7:0]  rx_byte;
  } in_word_t;

  typedef struct packed {
    okind_t      out_kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic        success;
    err_t        error_code;
    logic [15:0] read_value;
  } out_word_t;

  // one burst handed from the transaction logic to the emitter
  typedef struct packed {
    logic        load;
    logic        is_req;
    logic [7:0]  slave_id;
    logic [7:0]  func;
    logic [15:0] reg_address;
    logic [15:0] payload;
    logic        success;
    err_t        error_code;
    logic [15:0] read_value;
  } burst_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[src/mrtu_emit.sv]
// ----------------------------------------------------------------------------
// mrtu_emit
// Result emitter: sends an 8-word request with its CRC, or one finish word.
// ----------------------------------------------------------------------------
module mrtu_emit import mrtu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  burst_t    burst,
  output logic      free,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  logic        vld_r;
  logic        is_req_r;
  logic [2:0]  beat_r;
  logic [15:0] crc_r;
  logic [7:0]  req_r [REQ_BODY_BYTES];
  logic        success_r;
  err_t        err_r;
  logic [15:0] value_r;

  logic        take;
  logic        final_beat;
  logic [7:0]  body_byte;

  assign take       = vld_r && !out_stall;
  assign final_beat = !is_req_r || (beat_r == BEAT_LAST);
  assign free       = !vld_r || (take && final_beat);
  assign body_byte  = (beat_r < BEAT_CRC_LO) ? req_r[beat_r] : 8'h00;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      beat_r <= '0;
    end else begin
      if (burst.load) begin
        vld_r  <= 1'b1;
        beat_r <= '0;
      end else if (take) begin
        if (final_beat) begin
          vld_r <= 1'b0;
        end else begin
          beat_r <= beat_r + 3'd1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (burst.load) begin
      is_req_r  <= burst.is_req;
      crc_r     <= CRC_INIT;
      req_r[0]  <= burst.slave_id;
      req_r[1]  <= burst.func;
      req_r[2]  <= burst.reg_address[15:8];
      req_r[3]  <= burst.reg_address[7:0];
      req_r[4]  <= burst.payload[15:8];
      req_r[5]  <= burst.payload[7:0];
      success_r <= burst.success;
      err_r     <= burst.error_code;
      value_r   <= burst.read_value;
    end else if (take && is_req_r && (beat_r < BEAT_CRC_LO)) begin
      // CRC accumulates as each body byte leaves
      crc_r <= crc_byte(crc_r, body_byte);
    end
  end

  assign out_valid = vld_r;

  always_comb begin
    out_data = '0;
    if (is_req_r) begin
      out_data.out_kind = OUT_TX;
      out_data.last     = (beat_r == BEAT_LAST);
      if (beat_r == BEAT_CRC_LO) begin
        out_data.tx_byte = crc_r[7:0];
      end else if (beat_r == BEAT_LAST) begin
        out_data.tx_byte = crc_r[15:8];
      end else begin
        out_data.tx_byte = body_byte;
      end
    end else begin
      out_data.out_kind   = OUT_DONE;
      out_data.last       = 1'b1;
      out_data.success    = success_r;
      out_data.error_code = err_r;
      out_data.read_value = value_r;
    end
  end

endmodule

[src/modbus_rtu_master_transaction.sv]
// ----------------------------------------------------------------------------
// modbus_rtu_master_transaction
// Modbus RTU master, one transaction at a time, with CRC-16/MODBUS.
// ----------------------------------------------------------------------------
// Input words (in_valid/in_stall, in_data) are start read, start write,
// received byte or time tick. A start emits eight transmit words on the
// out_ channel (slave, function, address, quantity or value, CRC low/high);
// the response bytes are counted and CRC-checked as they arrive and a
// finish word reports success, error code and the read value. Ticks time
// out an incomplete response; a start while busy gets a busy finish word.
// Each word passes through the input register, and its first result is
// then shown from the emitter register.
// Throughput: one input word per cycle for bytes and ticks while no word
// waits for the emitter. A start keeps the single emitter busy until its
// request burst has drained; a word behind it that needs the emitter
// (another start, a final byte or a timeout tick) waits in the input
// register until then. A finish word occupies the emitter until taken.
// out_stall freezes the emitter; the input register then stalls only when
// the word waiting in it needs the emitter. Reset (rst_n low, synchronous)
// drops words in flight, clears the transaction and sets timeout to 1000.
// The APB port holds timeout_ticks at address 0; pready is tied high.
// ----------------------------------------------------------------------------
module modbus_rtu_master_transaction import mrtu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        in_vld_r;
  in_word_t    in_r;

  logic        busy_r,        busy_nxt;
  logic        op_is_write_r, op_is_write_nxt;
  logic [3:0]  rx_count_r,    rx_count_nxt;
  logic [15:0] running_crc_r, running_crc_nxt;
  logic [7:0]  crc_low_r,     crc_low_nxt;
  logic [15:0] data_word_r,   data_word_nxt;
  logic [15:0] elapsed_r,     elapsed_nxt;
  logic [15:0] timeout_r;

  burst_t      burst;
  logic        emit_free;
  logic        gen;
  logic        adv;
  logic        in_take;
  logic [3:0]  body_len;
  logic [15:0] rsp_crc;
  logic        crc_ok;

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_TIMEOUT) ? {16'h0000, timeout_r} : 32'h0000_0000;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TIMEOUT)) begin
      timeout_r <= pwdata[15:0];
    end
  end

  // input register
  assign in_stall = in_vld_r && !adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_r <= '0;
    end else if (in_take) begin
      in_r <= in_data;
    end
  end

  assign body_len = op_is_write_r ? BODY_LEN_WRITE : BODY_LEN_READ;
  assign rsp_crc  = {in_r.rx_byte, crc_low_r};
  assign crc_ok   = (rsp_crc == running_crc_r);

  always_comb begin
    busy_nxt        = busy_r;
    op_is_write_nxt = op_is_write_r;
    rx_count_nxt    = rx_count_r;
    running_crc_nxt = running_crc_r;
    crc_low_nxt     = crc_low_r;
    data_word_nxt   = data_word_r;
    elapsed_nxt     = elapsed_r;
    burst           = '0;
    gen             = 1'b0;
    unique case (in_r.kind)
      KIND_READ, KIND_WRITE: begin
        gen = 1'b1;
        if (busy_r) begin
          burst.error_code = ERR_BUSY;
        end else begin
          burst.is_req      = 1'b1;
          burst.slave_id    = in_r.slave_id;
          burst.reg_address = in_r.reg_address;
          if (in_r.kind == KIND_WRITE) begin
            burst.func    = FC_WRITE;
            burst.payload = in_r.write_value;
          end else begin
            burst.func    = FC_READ;
            burst.payload = READ_QTY;
          end
          busy_nxt        = 1'b1;
          op_is_write_nxt = (in_r.kind == KIND_WRITE);
          rx_count_nxt    = '0;
          running_crc_nxt = CRC_INIT;
          crc_low_nxt     = '0;
          data_word_nxt   = '0;
          elapsed_nxt     = '0;
        end
      end
      KIND_RXBYTE: begin
        if (busy_r) begin
          rx_count_nxt = rx_count_r + 4'd1;
          if (rx_count_r < body_len) begin
            running_crc_nxt = crc_byte(running_crc_r, in_r.rx_byte);
            if (!op_is_write_r && (rx_count_r == RX_IDX_DATA_HI)) begin
              data_word_nxt[15:8] = in_r.rx_byte;
            end else if (!op_is_write_r && (rx_count_r == RX_IDX_DATA_LO)) begin
              data_word_nxt[7:0] = in_r.rx_byte;
            end
          end else if (rx_count_r == body_len) begin
            crc_low_nxt = in_r.rx_byte;
          end else begin
            gen              = 1'b1;
            busy_nxt         = 1'b0;
            burst.success    = crc_ok;
            burst.error_code = crc_ok ? ERR_OK : ERR_CRC;
            burst.read_value = (crc_ok && !op_is_write_r) ? data_word_r : 16'h0000;
          end
        end
      end
      KIND_TICK: begin
        if (busy_r) begin
          if (elapsed_r < ELAPSED_MAX) begin
            elapsed_nxt = elapsed_r + 16'd1;
          end
          if (elapsed_nxt >= timeout_r) begin
            gen              = 1'b1;
            busy_nxt         = 1'b0;
            burst.error_code = ERR_TIMEOUT;
          end
        end
      end
      default: begin
      end
    endcase
    adv        = in_vld_r && (!gen || emit_free);
    burst.load = adv && gen;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r        <= 1'b0;
      op_is_write_r <= 1'b0;
      rx_count_r    <= '0;
      running_crc_r <= CRC_INIT;
      crc_low_r     <= '0;
      data_word_r   <= '0;
      elapsed_r     <= '0;
    end else if (adv) begin
      busy_r        <= busy_nxt;
      op_is_write_r <= op_is_write_nxt;
      rx_count_r    <= rx_count_nxt;
      running_crc_r <= running_crc_nxt;
      crc_low_r     <= crc_low_nxt;
      data_word_r   <= data_word_nxt;
      elapsed_r     <= elapsed_nxt;
    end
  end

  mrtu_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .burst     (burst),
    .free      (emit_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[src/mrtu_chk.sv]
// ----------------------------------------------------------------------------
// mrtu_chk
// Port-level checks for the Modbus RTU master, bound to the top level.
// ----------------------------------------------------------------------------
`include "modbus_rtu_master_transaction_assert.svh"

module mrtu_chk import mrtu_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input out_word_t   out_data
);

  logic held;
  logic is_tx;
  logic tx_mid;
  logic done_ok;

  assign held    = out_valid && out_stall;
  assign is_tx   = (out_data.out_kind == OUT_TX);
  assign tx_mid  = out_valid && !out_stall && is_tx && !out_data.last;
  assign done_ok = (out_data.error_code == ERR_OK) && (out_data.out_kind == OUT_DONE)
                   && out_data.last;

  `MRTU_CHECK(a_out_hold, held |=> out_valid && $stable(out_data), "stalled word changed")

  // a request burst never breaks off before its last word
  `MRTU_CHECK(a_burst_cont, tx_mid |=> out_valid && is_tx, "request burst cut short")

  `MRTU_CHECK(a_success_ok, out_valid && out_data.success |-> done_ok, "success word malformed")

  `MRTU_CHECK_RST(a_reset_idle, !rst_n |=> !out_valid && !in_stall, "not idle after reset")

endmodule

bind modbus_rtu_master_transaction mrtu_chk u_chk (.*);
